@@ design/sbl_pkg.sv @@
`default_nettype none
package sbl_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WREG_W = 11;
   localparam int HREG_W = 13;
   localparam int CSR_W  = 13;
   localparam int PIX_W  = 24;
   localparam int QDEPTH = 4;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
   localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(768);

   typedef logic [8:0][PIX_W-1:0] win_type;

   typedef struct packed {
      win_type win;
      logic    last;
      logic    fend;
   } entry_type;

   // Window element [i][j] sits at index 3*i+j; i is the row, j the column.
   function automatic win_type shift_win(input win_type w, input logic [PIX_W-1:0] top,
                                         input logic [PIX_W-1:0] mid,
                                         input logic [PIX_W-1:0] bot);
      win_type r;
      r[0] = w[1]; r[1] = w[2]; r[2] = top;
      r[3] = w[4]; r[4] = w[5]; r[5] = mid;
      r[6] = w[7]; r[7] = w[8]; r[8] = bot;
      return r;
   endfunction
endpackage
`default_nettype wire

@@ design/sbl_queue.sv @@
`default_nettype none
module sbl_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sbl_pkg::entry_type push_data,
   input  wire logic               pop,
   output sbl_pkg::entry_type      head,
   output logic                    not_empty,
   output logic                    room2
);
   import sbl_pkg::*;
   localparam int PW = $clog2(QDEPTH);

   entry_type             mem_ff [QDEPTH];
   logic [PW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]           cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign room2     = (cnt_ff <= (PW+1)'(QDEPTH-2));
endmodule
`default_nettype wire

@@ design/sbl_front.sv @@
`default_nettype none
module sbl_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [sbl_pkg::WREG_W-1:0]  width_cfg,
   input  wire logic [sbl_pkg::HREG_W-1:0]  height_cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [7:0]                  req_red,
   input  wire logic [7:0]                  req_green,
   input  wire logic [7:0]                  req_blue,
   output logic                             q_push,
   output sbl_pkg::entry_type               q_data,
   input  wire logic                        q_room2
);
   import sbl_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_TAIL} fstate_type;

   fstate_type          state_ff;
   logic [COL_W-1:0]    col_ff, ccol_ff;
   logic [ROW_W-1:0]    row_ff, crow_ff;
   logic                drain_ff, pmode_ff;
   win_type             win_ff;
   logic [PIX_W-1:0]    px_ff, up_rd_ff, mid_rd_ff;

   logic [PIX_W-1:0]    upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0]    middle_mem [MAX_WIDTH];

   logic [WREG_W-1:0]   w_eff;
   logic [HREG_W-1:0]   h_eff;
   logic [COL_W-1:0]    wm1, col_c;
   logic [ROW_W-1:0]    hm1, row_c;
   logic                accept, useful;
   logic [PIX_W-1:0]    top, mid, bot;
   win_type             win_shift, win_tail;
   logic                e1, e2, at_end;

   always_comb begin
      if (width_cfg == '0) w_eff = WREG_W'(1);
      else if (width_cfg > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
      else w_eff = width_cfg;
      if (height_cfg == '0) h_eff = HREG_W'(1);
      else if (height_cfg > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
      else h_eff = height_cfg;
      wm1   = COL_W'(w_eff - 1'b1);
      hm1   = ROW_W'(h_eff - 1'b1);
      col_c = (WREG_W'(col_ff) >= w_eff) ? wm1 : col_ff;
      row_c = (HREG_W'(row_ff) >= h_eff) ? hm1 : row_ff;
   end

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;
   assign useful    = drain_ff ? req_type : !req_type;

   always_comb begin
      if (pmode_ff) begin
         top = (crow_ff >= ROW_W'(2)) ? up_rd_ff : '0;
         mid = (crow_ff >= ROW_W'(1)) ? mid_rd_ff : '0;
         bot = px_ff;
      end else begin
         top = (crow_ff >= ROW_W'(1)) ? up_rd_ff : '0;
         mid = mid_rd_ff;
         bot = '0;
      end
      // A new row starts from an empty window.
      win_shift = shift_win((ccol_ff == '0) ? win_type'('0) : win_ff, top, mid, bot);
      win_tail  = shift_win(win_ff, '0, '0, '0);
      at_end    = (ccol_ff == wm1);
      e1 = (ccol_ff != '0) && (!pmode_ff || crow_ff != '0);
      e2 = at_end && (!pmode_ff || crow_ff != '0);
   end

   always_comb begin
      q_push = 1'b0;
      q_data = '{win: win_shift, last: !e2, fend: 1'b0};
      if (state_ff == F_SHIFT) begin
         q_push = q_room2 && e1;
      end else if (state_ff == F_TAIL) begin
         q_push = 1'b1;
         q_data = '{win: win_tail, last: 1'b1, fend: !pmode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && useful) begin
         up_rd_ff  <= upper_mem[col_c];
         mid_rd_ff <= middle_mem[col_c];
      end
      if (state_ff == F_SHIFT && q_room2 && pmode_ff) begin
         upper_mem[ccol_ff]  <= mid_rd_ff;
         middle_mem[ccol_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
         win_ff   <= '0;
         pmode_ff <= 1'b0;
         ccol_ff  <= '0;
         crow_ff  <= '0;
         px_ff    <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept && useful) begin
                  px_ff    <= {req_red, req_green, req_blue};
                  pmode_ff <= !drain_ff;
                  ccol_ff  <= col_c;
                  crow_ff  <= row_c;
                  state_ff <= F_SHIFT;
               end
            end
            F_SHIFT: begin
               if (q_room2) begin
                  win_ff <= win_shift;
                  if (at_end) begin
                     col_ff <= '0;
                     if (!pmode_ff) begin
                        row_ff   <= '0;
                        drain_ff <= 1'b0;
                     end else if (crow_ff >= hm1) begin
                        row_ff   <= crow_ff;
                        drain_ff <= 1'b1;
                     end else begin
                        row_ff <= crow_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= ccol_ff + 1'b1;
                  end
                  state_ff <= e2 ? F_TAIL : F_IDLE;
               end
            end
            F_TAIL: begin
               win_ff   <= win_tail;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ design/sbl_back.sv @@
`default_nettype none
module sbl_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sbl_pkg::entry_type head,
   input  wire logic               not_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_edge_red,
   output logic [7:0]              rsp_edge_green,
   output logic [7:0]              rsp_edge_blue,
   output logic                    rsp_last_of_run,
   output logic                    rsp_frame_end
);
   import sbl_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_SQ, B_ROOT, B_DONE} bstate_type;

   bstate_type          state_ff;
   logic [2:0][9:0]     ax_ff, ay_ff;
   logic [2:0][20:0]    s_ff;
   logic [2:0][7:0]     n_ff;
   logic [2:0][15:0]    nn_ff;
   logic [2:0]          big_ff;
   logic [2:0]          bit_ff;
   logic                last_ff, fend_ff;
   logic                valid_ff;
   logic [2:0][7:0]     out_ff;
   logic                olast_ff, ofend_ff;

   logic [2:0][9:0]     ax_c, ay_c;
   logic [2:0][7:0]     t_c, res_c;
   logic [2:0][15:0]    tt_c;
   logic [2:0][15:0]    rem_c;
   logic                out_free;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         logic [11:0] xp, xn, yp, yn, gx, gy;
         xp = 12'(head.win[2][23-8*ch -: 8]) + {3'b0, head.win[5][23-8*ch -: 8], 1'b0}
              + 12'(head.win[8][23-8*ch -: 8]);
         xn = 12'(head.win[0][23-8*ch -: 8]) + {3'b0, head.win[3][23-8*ch -: 8], 1'b0}
              + 12'(head.win[6][23-8*ch -: 8]);
         yp = 12'(head.win[6][23-8*ch -: 8]) + {3'b0, head.win[7][23-8*ch -: 8], 1'b0}
              + 12'(head.win[8][23-8*ch -: 8]);
         yn = 12'(head.win[0][23-8*ch -: 8]) + {3'b0, head.win[1][23-8*ch -: 8], 1'b0}
              + 12'(head.win[2][23-8*ch -: 8]);
         gx = (xp >= xn) ? xp - xn : xn - xp;
         gy = (yp >= yn) ? yp - yn : yn - yp;
         ax_c[ch] = gx[9:0];
         ay_c[ch] = gy[9:0];
         t_c[ch]  = n_ff[ch] | (8'd1 << bit_ff);
         tt_c[ch] = t_c[ch] * t_c[ch];
         rem_c[ch] = s_ff[ch][15:0] - nn_ff[ch];
         if (big_ff[ch]) res_c[ch] = 8'd255;
         else if (rem_c[ch] > 16'(n_ff[ch]) && n_ff[ch] != 8'd255) res_c[ch] = n_ff[ch] + 1'b1;
         else res_c[ch] = n_ff[ch];
      end
   end

   assign out_free  = !valid_ff || rsp_ready;
   assign pop       = (state_ff == B_IDLE) && not_empty;
   assign rsp_valid = valid_ff;
   assign rsp_edge_red    = out_ff[0];
   assign rsp_edge_green  = out_ff[1];
   assign rsp_edge_blue   = out_ff[2];
   assign rsp_last_of_run = olast_ff;
   assign rsp_frame_end   = ofend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         bit_ff   <= '0;
      end else begin
         if (valid_ff && rsp_ready && state_ff != B_DONE) valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (not_empty) begin
                  ax_ff    <= ax_c;
                  ay_ff    <= ay_c;
                  last_ff  <= head.last;
                  fend_ff  <= head.fend;
                  state_ff <= B_SQ;
               end
            end
            B_SQ: begin
               for (int ch = 0; ch < 3; ch++) begin
                  logic [20:0] sq;
                  sq = 21'(ax_ff[ch]) * 21'(ax_ff[ch]) + 21'(ay_ff[ch]) * 21'(ay_ff[ch]);
                  s_ff[ch]   <= sq;
                  big_ff[ch] <= (sq > 21'd65280);
               end
               n_ff     <= '0;
               nn_ff    <= '0;
               bit_ff   <= 3'd7;
               state_ff <= B_ROOT;
            end
            B_ROOT: begin
               // One result bit per cycle for each channel, most significant first.
               for (int ch = 0; ch < 3; ch++) begin
                  if (21'(tt_c[ch]) <= s_ff[ch]) begin
                     n_ff[ch]  <= t_c[ch];
                     nn_ff[ch] <= tt_c[ch];
                  end
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) state_ff <= B_DONE;
            end
            B_DONE: begin
               // A response leaving in this cycle frees the output register.
               if (out_free) begin
                  out_ff   <= res_c;
                  olast_ff <= last_ff;
                  ofend_ff <= fend_ff;
                  valid_ff <= 1'b1;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ design/sobel_edge_magnitude_3x3_core.sv @@
`default_nettype none
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// The request channel takes one pixel (req_type low) or one drain item
// (req_type high) per transfer. After the last pixel of a frame the source
// sends one drain item per column to flush the bottom row. Each response
// transfer carries the rounded, saturated gradient magnitude of the three
// channels; rsp_last_of_run marks the last response caused by one request
// and rsp_frame_end marks the bottom-right pixel of the frame.
// The front end accepts a pixel or drain request in F_IDLE, updates the
// window in F_SHIFT and, when it ends a row with two responses, in F_TAIL;
// it drops an ignored request without leaving F_IDLE. Its pace is set by the
// registered line buffer read and the window update. The back end handles
// each response in steps (gradients, squares, eight square-root steps, rounding),
// so that unit sets the sustained rate. A four-entry queue separates the two,
// and a response waiting in the output register does not stop the back end
// from starting the next one. Reset clears the counters and the window and
// sets the frame to 1024x768; the line buffers need no clearing pass. When the
// receiver stalls, the queue fills and the request ready drops.
module sobel_edge_magnitude_3x3_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_type,
   input  wire logic [7:0]                 req_red,
   input  wire logic [7:0]                 req_green,
   input  wire logic [7:0]                 req_blue,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_edge_red,
   output logic [7:0]                      rsp_edge_green,
   output logic [7:0]                      rsp_edge_blue,
   output logic                            rsp_last_of_run,
   output logic                            rsp_frame_end,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [sbl_pkg::CSR_W-1:0]  csr_wdata
);
   import sbl_pkg::*;

   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic              q_push, q_pop, q_not_empty, q_room2;
   entry_type         q_in, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata[WREG_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata[HREG_W-1:0];
            default: ;
         endcase
      end
   end

   sbl_front u_front (
      .clock(clock), .reset(reset),
      .width_cfg(width_ff), .height_cfg(height_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .q_push(q_push), .q_data(q_in), .q_room2(q_room2)
   );

   sbl_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .pop(q_pop),
      .head(q_head), .not_empty(q_not_empty), .room2(q_room2)
   );

   sbl_back u_back (
      .clock(clock), .reset(reset),
      .head(q_head), .not_empty(q_not_empty), .pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_edge_red(rsp_edge_red), .rsp_edge_green(rsp_edge_green),
      .rsp_edge_blue(rsp_edge_blue), .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_end(rsp_frame_end)
   );
endmodule
`default_nettype wire
